// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define SED_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SED_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SED_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define SED_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

// ===== rtl/core/sed_pkg.sv =====
package sed_pkg;

    // Field widths and fixed-point format.
    localparam int COORD_W         = 24;
    localparam int COORD_FRAC_BITS = 8;
    localparam int COEFF_W         = 32;
    localparam int PROD_W          = COEFF_W + COORD_W;
    localparam int LINE_W          = 57;
    localparam int LO_W            = 29;
    localparam int HI_W            = LINE_W - LO_W;
    localparam int NUM_W           = 81;
    localparam int MAG_W           = 80;
    localparam int LIMB_W          = 27;
    localparam int LIMB_N          = 3;
    localparam int SQ_W            = 2 * LIMB_W;
    localparam int DEN_W           = 113;
    localparam int N2_W            = 160;
    localparam int ACC_W           = 165;
    localparam int Q_W             = 25;
    localparam int DIST_W          = 24;
    localparam int STATUS_W        = 2;

    // Configuration port.
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = PADDR_W - 3;

    localparam logic [REG_IDX_W-1:0] REG_R0_C0C1   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_R0C2_R1C0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_R1_C1C2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_R2_C0C1   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_R2_C2     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NORMAL    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEN_ZERO  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic signed [COEFF_W-1:0] coeff_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } point_t;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        coeff_t f00;
        coeff_t f01;
        coeff_t f02;
        coeff_t f10;
        coeff_t f11;
        coeff_t f12;
        coeff_t f20;
        coeff_t f21;
        coeff_t f22;
    } fmat_t;

    typedef struct packed {
        logic signed [LINE_W-1:0]  l1_0;
        logic signed [LINE_W-1:0]  l1_1;
        logic signed [LINE_W-1:0]  l1_2;
        logic signed [LINE_W-1:0]  l2_0;
        logic signed [LINE_W-1:0]  l2_1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } line_t;

    typedef struct packed {
        logic [N2_W-1:0]  n2;
        logic [DEN_W-1:0] den;
        logic             den_zero;
    } quad_t;

    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [ACC_W-1:0] dq;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
        logic             den_zero;
    } root_t;

endpackage

// ===== rtl/core/sed_line_unit.sv =====
module sed_line_unit import sed_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  fmat_t  fmat,
    input  logic   in_valid,
    input  point_t pt,
    output logic   out_valid,
    output line_t  line
);

    logic signed [PROD_W-1:0]  prod_reg [10];
    logic signed [COORD_W-1:0] x2_reg;
    logic signed [COORD_W-1:0] y2_reg;
    logic                      valid_a_reg;
    line_t                     line_reg;
    logic                      valid_b_reg;

    // Coefficient by coordinate products of both epipolar lines.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= fmat.f00 * pt.first_x;
            prod_reg[1] <= fmat.f01 * pt.first_y;
            prod_reg[2] <= fmat.f10 * pt.first_x;
            prod_reg[3] <= fmat.f11 * pt.first_y;
            prod_reg[4] <= fmat.f20 * pt.first_x;
            prod_reg[5] <= fmat.f21 * pt.first_y;
            prod_reg[6] <= fmat.f00 * pt.second_x;
            prod_reg[7] <= fmat.f10 * pt.second_y;
            prod_reg[8] <= fmat.f01 * pt.second_x;
            prod_reg[9] <= fmat.f11 * pt.second_y;
            x2_reg      <= pt.second_x;
            y2_reg      <= pt.second_y;
        end
    end

    // Line sums; the homogeneous coordinate one is a shift.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_reg.l1_0 <= LINE_W'(prod_reg[0]) + LINE_W'(prod_reg[1])
                           + (LINE_W'(fmat.f02) <<< COORD_FRAC_BITS);
            line_reg.l1_1 <= LINE_W'(prod_reg[2]) + LINE_W'(prod_reg[3])
                           + (LINE_W'(fmat.f12) <<< COORD_FRAC_BITS);
            line_reg.l1_2 <= LINE_W'(prod_reg[4]) + LINE_W'(prod_reg[5])
                           + (LINE_W'(fmat.f22) <<< COORD_FRAC_BITS);
            line_reg.l2_0 <= LINE_W'(prod_reg[6]) + LINE_W'(prod_reg[7])
                           + (LINE_W'(fmat.f20) <<< COORD_FRAC_BITS);
            line_reg.l2_1 <= LINE_W'(prod_reg[8]) + LINE_W'(prod_reg[9])
                           + (LINE_W'(fmat.f21) <<< COORD_FRAC_BITS);
            line_reg.x2   <= x2_reg;
            line_reg.y2   <= y2_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign line      = line_reg;
    assign out_valid = valid_b_reg;

endmodule

// ===== rtl/core/sed_quad_unit.sv =====
module sed_quad_unit import sed_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  line_t line,
    output logic  out_valid,
    output quad_t quad
);

    logic signed [LINE_W-1:0]        sq_op [4];
    logic signed [HI_W-1:0]          hi    [4];
    logic signed [LO_W:0]            lo    [4];

    logic signed [2*HI_W-1:0]        hh_reg [4];
    logic signed [HI_W+LO_W:0]       hl_reg [4];
    logic        [2*LO_W-1:0]        ll_reg [4];
    logic signed [COORD_W+HI_W-1:0]  hx_reg;
    logic signed [COORD_W+LO_W:0]    lx_reg;
    logic signed [COORD_W+HI_W-1:0]  hy_reg;
    logic signed [COORD_W+LO_W:0]    ly_reg;
    logic signed [LINE_W-1:0]        l12_reg;

    logic signed [DEN_W:0]           sq_full [4];
    logic signed [NUM_W-1:0]         num_reg;
    logic        [DEN_W-1:0]         sq_reg  [4];

    logic        [NUM_W-1:0]         num_abs;
    logic        [MAG_W-1:0]         mag_reg;
    logic        [DEN_W-1:0]         den_e_reg;

    logic        [LIMB_N*LIMB_W-1:0] mag_ext;
    logic        [LIMB_W-1:0]        a0, a1, a2;
    logic        [SQ_W-1:0]          p00_reg, p11_reg, p22_reg, p01_reg, p02_reg, p12_reg;
    logic        [DEN_W-1:0]         den_f_reg;
    logic                            zero_f_reg;

    quad_t                           quad_reg;
    logic        [4:0]               valid_reg;

    // Split the four squared line terms into a signed high half and an unsigned low half.
    always_comb
    begin
        sq_op[0] = line.l1_0;
        sq_op[1] = line.l1_1;
        sq_op[2] = line.l2_0;
        sq_op[3] = line.l2_1;
        for (int k = 0; k < 4; k++)
        begin
            hi[k] = sq_op[k][LINE_W-1:LO_W];
            lo[k] = $signed({1'b0, sq_op[k][LO_W-1:0]});
        end
    end

    // Partial products of the residual and of the four squares.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                hh_reg[k] <= hi[k] * hi[k];
                hl_reg[k] <= hi[k] * lo[k];
                ll_reg[k] <= lo[k][LO_W-1:0] * lo[k][LO_W-1:0];
            end
            hx_reg  <= line.x2 * hi[0];
            lx_reg  <= line.x2 * lo[0];
            hy_reg  <= line.y2 * hi[1];
            ly_reg  <= line.y2 * lo[1];
            l12_reg <= line.l1_2;
        end
    end

    // Recombine the halves of every square.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sq_full[k] = ((DEN_W+1)'(hh_reg[k]) <<< (2 * LO_W))
                       + ((DEN_W+1)'(hl_reg[k]) <<< (LO_W + 1))
                       + (DEN_W+1)'($signed({1'b0, ll_reg[k]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= (NUM_W'(hx_reg) <<< LO_W) + NUM_W'(lx_reg)
                     + (NUM_W'(hy_reg) <<< LO_W) + NUM_W'(ly_reg)
                     + (NUM_W'(l12_reg) <<< COORD_FRAC_BITS);
            for (int k = 0; k < 4; k++)
            begin
                sq_reg[k] <= sq_full[k][DEN_W-1:0];
            end
        end
    end

    // Denominator sum and residual magnitude.
    assign num_abs = num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_e_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            mag_reg   <= num_abs[MAG_W-1:0];
        end
    end

    // Residual squared as limb products.
    assign mag_ext = (LIMB_N*LIMB_W)'(mag_reg);
    assign a0      = mag_ext[LIMB_W-1:0];
    assign a1      = mag_ext[2*LIMB_W-1:LIMB_W];
    assign a2      = mag_ext[3*LIMB_W-1:2*LIMB_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg    <= a0 * a0;
            p11_reg    <= a1 * a1;
            p22_reg    <= a2 * a2;
            p01_reg    <= a0 * a1;
            p02_reg    <= a0 * a2;
            p12_reg    <= a1 * a2;
            den_f_reg  <= den_e_reg;
            zero_f_reg <= (den_e_reg == '0);
        end
    end

    // Cross terms appear twice, hence the extra shift by one.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quad_reg.n2 <= N2_W'(p00_reg)
                         + (N2_W'(p01_reg) << (LIMB_W + 1))
                         + (N2_W'(p11_reg) << (2 * LIMB_W))
                         + (N2_W'(p02_reg) << (2 * LIMB_W + 1))
                         + (N2_W'(p12_reg) << (3 * LIMB_W + 1))
                         + (N2_W'(p22_reg) << (4 * LIMB_W));
            quad_reg.den      <= den_f_reg;
            quad_reg.den_zero <= zero_f_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    assign quad      = quad_reg;
    assign out_valid = valid_reg[4];

endmodule

// ===== rtl/core/sed_root_unit.sv =====
module sed_root_unit import sed_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  quad_t          quad,
    output logic           out_valid,
    output logic [Q_W-1:0] q,
    output logic           den_zero
);

    // Each stage decides one bit of q, keeping rem = n2 - q*q*den and dq = q*den.
    root_t          st_init;
    root_t          st_in  [Q_W];
    root_t          st_reg [Q_W];
    logic [Q_W-1:0] v_in;
    logic [Q_W-1:0] v_reg;

    always_comb
    begin
        st_init          = '0;
        st_init.rem      = ACC_W'(quad.n2);
        st_init.den      = quad.den;
        st_init.den_zero = quad.den_zero;
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_digit
        localparam int K = Q_W - 1 - s;

        logic [ACC_W-1:0] term;
        logic             take;
        root_t            digit_next;

        if (s == 0)
        begin : g_first
            assign st_in[s] = st_init;
            assign v_in[s]  = in_valid;
        end
        else
        begin : g_rest
            assign st_in[s] = st_reg[s-1];
            assign v_in[s]  = v_reg[s-1];
        end

        // Growth of q*q*den when bit K is set.
        assign term = (st_in[s].dq << (K + 1)) + (ACC_W'(st_in[s].den) << (2 * K));
        assign take = (term <= st_in[s].rem);

        always_comb
        begin
            digit_next = st_in[s];
            if (take)
            begin
                digit_next.rem = st_in[s].rem - term;
                digit_next.dq  = st_in[s].dq + (ACC_W'(st_in[s].den) << K);
                digit_next.q   = st_in[s].q | (Q_W'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[s] <= digit_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_in[s];
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign q         = st_reg[Q_W-1].q;
    assign den_zero  = st_reg[Q_W-1].den_zero;

endmodule

// ===== rtl/core/sampson_epipolar_distance.sv =====
// An accepted point word passes the line, square and root units and then the output register.
// Throughput: one word per cycle while not stalled; the 25 square-root digit stages and the
// split multipliers of the square unit and the products of the line unit are each fully pipelined.
// The pipeline stalls only when both the output register and the skid register hold words.
// Reset (rst_n low, asynchronous) clears all valid bits and sets every coefficient to zero.
`include "assert_macros.svh"

module sampson_epipolar_distance import sed_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               point_valid,
    output logic               point_ready,
    input  point_t             point,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    logic [PDATA_W-1:0]   coeff0_reg, coeff1_reg, coeff2_reg, coeff3_reg;
    logic [COEFF_W-1:0]   coeff4_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    fmat_t                fmat;

    logic                 adv;
    logic                 line_valid;
    line_t                line;
    logic                 quad_valid;
    quad_t                quad;
    logic                 root_valid;
    logic [Q_W-1:0]       root_q;
    logic                 root_den_zero;

    result_t              result_next;
    result_t              result_reg;
    result_t              skid_reg;
    logic                 result_valid_reg;
    logic                 skid_valid_reg;

    // Register file access.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff0_reg <= '0;
            coeff1_reg <= '0;
            coeff2_reg <= '0;
            coeff3_reg <= '0;
            coeff4_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_R0_C0C1:   coeff0_reg <= pwdata;
                REG_R0C2_R1C0: coeff1_reg <= pwdata;
                REG_R1_C1C2:   coeff2_reg <= pwdata;
                REG_R2_C0C1:   coeff3_reg <= pwdata;
                REG_R2_C2:     coeff4_reg <= pwdata[COEFF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_R0_C0C1:   prdata = coeff0_reg;
            REG_R0C2_R1C0: prdata = coeff1_reg;
            REG_R1_C1C2:   prdata = coeff2_reg;
            REG_R2_C0C1:   prdata = coeff3_reg;
            REG_R2_C2:     prdata = PDATA_W'(coeff4_reg);
            default:       prdata = '0;
        endcase
    end

    // Unpack the matrix.
    assign fmat.f00 = coeff0_reg[COEFF_W-1:0];
    assign fmat.f01 = coeff0_reg[PDATA_W-1:COEFF_W];
    assign fmat.f02 = coeff1_reg[COEFF_W-1:0];
    assign fmat.f10 = coeff1_reg[PDATA_W-1:COEFF_W];
    assign fmat.f11 = coeff2_reg[COEFF_W-1:0];
    assign fmat.f12 = coeff2_reg[PDATA_W-1:COEFF_W];
    assign fmat.f20 = coeff3_reg[COEFF_W-1:0];
    assign fmat.f21 = coeff3_reg[PDATA_W-1:COEFF_W];
    assign fmat.f22 = coeff4_reg;

    // The whole pipeline moves unless the skid register is occupied.
    assign adv         = !skid_valid_reg;
    assign point_ready = adv;

    sed_line_unit u_line
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .fmat      (fmat),
        .in_valid  (point_valid),
        .pt        (point),
        .out_valid (line_valid),
        .line      (line)
    );

    sed_quad_unit u_quad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (line_valid),
        .line      (line),
        .out_valid (quad_valid),
        .quad      (quad)
    );

    sed_root_unit u_root
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (quad_valid),
        .quad      (quad),
        .out_valid (root_valid),
        .q         (root_q),
        .den_zero  (root_den_zero)
    );

    // Zero denominator wins over saturation.
    always_comb
    begin
        result_next.distance = root_q[DIST_W-1:0];
        result_next.status   = ST_NORMAL;
        priority if (root_den_zero)
        begin
            result_next.distance = DIST_MAX;
            result_next.status   = ST_DEN_ZERO;
        end
        else if (root_q[Q_W-1])
        begin
            result_next.distance = DIST_MAX;
            result_next.status   = ST_SATURATED;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (root_valid)
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
        else if (result_ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (root_valid)
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_reg <= result_next;
                end
                else
                begin
                    skid_reg <= result_next;
                end
            end
        end
        else if (result_ready)
        begin
            result_reg <= skid_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SED_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_valid_reg, result_valid_reg)
    `SED_ASSERT_IMPL(a_flag_means_max, clk, rst_n, result_valid_reg && (result_reg.status != ST_NORMAL), result_reg.distance == DIST_MAX)
    `SED_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !result_ready, skid_valid_reg && $stable(skid_reg))

endmodule
